// File: rtl/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

   // Default width of the integer taken on the request channel.
   localparam int VALUE_BITS_DEFAULT = 32;

   // Character codes.
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   // Largest value a single decimal digit may hold.
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// File: rtl/int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_value (VALUE_BITS, signed)
// rsp       out        rsp_valid/rsp_stall rsp_ascii_char (7), rsp_last_char (1)
//
// A number passes through an accept step in idle, one shift-and-add-3 step per value bit, a
// step for a minus sign if negative, one per digit place (leading zero dropped or character
// sent) and one to end the zero scan; the sign and character steps wait on a stalled beat.
// Reset is synchronous and active high; it clears the state machine and the output valid.
// A stalled beat holds the output register, and the request channel is stalled until the
// last character of a number is loaded.

module int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [6:0]                   rsp_ascii_char,
   output      logic                         rsp_last_char
);

   import itoa_pkg::*;

   // Decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1); log10(2) is
   // taken as 0.301, which rounds the count up over the whole parameter range.
   localparam int DIGITS = (VALUE_BITS * 301) / 1000 + 1;
   localparam int BCD_W  = DIGITS * 4;
   localparam int CNT_W  = $clog2(VALUE_BITS);
   localparam int DIG_W  = $clog2(DIGITS + 1);

   state_type          state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]   bcd_adj;
   logic [3:0]         top_digit;
   logic               out_free;
   logic               req_accept;

   // Each digit that reached five or more gets three added before the shift, so the
   // doubling carries correctly into the next decimal place.
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] > 4'd4) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   assign top_digit  = bcd_ff[BCD_W-1 -: 4];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // The magnitude is kept unsigned, so the most negative value needs no
               // special handling.
               neg_in     = req_value[VALUE_BITS-1];
               mag_in     = req_value[VALUE_BITS-1] ? (~$unsigned(req_value)) +
                            VALUE_BITS'(1) : $unsigned(req_value);
               bcd_in     = '0;
               bit_cnt_in = CNT_W'(VALUE_BITS - 1);
               dig_cnt_in = DIG_W'(DIGITS);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Leading zeros are dropped one a cycle; the last digit always stays, so
            // zero still prints as a single character.
            if (top_digit == 4'd0 && dig_cnt_ff > DIG_W'(1)) begin
               bcd_in     = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - DIG_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {3'd0, top_digit};
               rsp_last_in  = (dig_cnt_ff == DIG_W'(1));
               bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in   = dig_cnt_ff - DIG_W'(1);
               if (dig_cnt_ff == DIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // Every digit handed out of the decimal register is a proper decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> top_digit <= DIGIT_MAX)
      else $error("non-decimal digit in conversion register");

   // Any beat on the result channel carries a minus sign or a digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == CHAR_MINUS ||
                     (rsp_ascii_char >= CHAR_ZERO &&
                      rsp_ascii_char <= CHAR_ZERO + {3'd0, DIGIT_MAX})))
      else $error("illegal character on result channel");

   // Loading the final digit returns the block to idle in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && dig_cnt_ff == DIG_W'(1))
      |=> (state_ff == ST_IDLE && rsp_valid && rsp_last_char))
      else $error("last character not followed by idle");

   // Leading zero removal never drops the final digit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> dig_cnt_ff != '0)
      else $error("digit count underflow");
`endif

endmodule

`default_nettype wire
